// ----- rtl/wbps_pkg.sv -----
// wbps_pkg: shared types and constants for the wildcard byte pattern scanner.
// Holds the transfer payload structs, field widths and register map codes.
// No dependencies.
package wbps_pkg;

    // Fixed field widths
    localparam int ADDR_W       = 64;
    localparam int OFFSET_W     = 26;                  // 64 MiB region
    localparam int SEEN_W       = OFFSET_W + 1;        // can hold the limit itself
    localparam int HIT_TOTAL_W  = 9;
    localparam int HIT_LIMIT_W  = 9;
    localparam int PAT_LEN_W    = 5;
    localparam int CARE_W       = 16;
    localparam int PAT_REG_BITS = 8 * CARE_W;          // bytes with a register
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;                   // 8-byte stride, 7 registers

    // Register map (index = paddr[5:3])
    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] REG_CARE_MASK    = 3'd2;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [2:0] REG_REGION_START = 3'd4;
    localparam logic [2:0] REG_MODULE_BASE  = 3'd5;
    localparam logic [2:0] REG_HIT_LIMIT    = 3'd6;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   result_kind;
        logic [ADDR_W-1:0]      match_address;
        logic [ADDR_W-1:0]      match_relative;
        logic [OFFSET_W-1:0]    match_offset;
        logic [HIT_TOTAL_W-1:0] hit_total;
        logic                   scan_status;
        logic                   final_result;
    } out_item_t;

endpackage

// ----- rtl/wbps_match.sv -----
// wbps_match: masked byte comparators between the byte window and the pattern.
// Depends on wbps_pkg.
module wbps_match #(
    parameter int PATTERN_MAX = 16
) (
    input  logic [PATTERN_MAX-1:0][7:0]                   window,      // newest at top
    input  logic [wbps_pkg::PAT_REG_BITS-1:0]             pattern,
    input  logic [wbps_pkg::CARE_W-1:0]                   care_mask,
    input  logic [((($clog2(PATTERN_MAX+1)) > wbps_pkg::PAT_LEN_W) ?
                   $clog2(PATTERN_MAX+1) : wbps_pkg::PAT_LEN_W)-1:0] pattern_len,
    output logic                                          window_match
);
    import wbps_pkg::*;

    // only pattern bytes with a register can be non-wildcard
    localparam int NCMP = (PATTERN_MAX < CARE_W) ? PATTERN_MAX : CARE_W;

    always_comb
    begin
        logic [7:0] got;
        window_match = 1'b1;
        for (int k = 0; k < NCMP; k++)
        begin
            // pattern byte k lines up with window slot PATTERN_MAX - len + k
            got = '0;
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                if (j + int'(pattern_len) == PATTERN_MAX + k)
                    got = window[j];
            end
            if (k < int'(pattern_len) && care_mask[k] && got != pattern[8*k +: 8])
                window_match = 1'b0;
        end
    end

endmodule

// ----- rtl/wildcard_byte_pattern_scan.sv -----
// wildcard_byte_pattern_scan: streaming wildcard byte signature scanner, top level.
// Depends on wbps_pkg and wbps_match.
//
//  channel   | dir | handshake             | transfer payload
//  ----------+-----+-----------------------+-------------------------------------
//  byte      | in  | byte_valid/byte_ready | in_item_t: data_byte, last_byte
//  result    | out | result_valid/_ready   | out_item_t: match report or summary
//  config    | in  | APB psel/penable      | 64-bit registers at 8*index
//
// One byte per cycle while the result side keeps up: a transfer lands in the
// input register, is compared and folded into the scan state when it is
// consumed, and its first result enters the output register at the same edge
// that updates the scan state. A byte that both matches and ends the region
// holds the next byte back: the summary leaves from a holding register behind
// the match report. A stalled result side stops the input register; the byte
// channel then takes at most one more transfer. Reset clears the scan state
// and loads register defaults; no clearing pass is needed.
module wildcard_byte_pattern_scan #(
    parameter int PATTERN_MAX = 16,
    parameter int MAX_HITS    = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // byte stream
    input  logic                                 byte_valid,
    output logic                                 byte_ready,
    input  wbps_pkg::in_item_t                   byte_item,
    // results
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output wbps_pkg::out_item_t                  result_item
);
    import wbps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int LX_W  = (LEN_W > PAT_LEN_W) ? LEN_W : PAT_LEN_W;
    localparam int CNT_W = $clog2(MAX_HITS + 1);
    localparam int CMP_W = (CNT_W > HIT_LIMIT_W) ? CNT_W : HIT_LIMIT_W;

    // ---------------- configuration registers ----------------
    logic [ADDR_W-1:0]      pattern_low_reg;
    logic [ADDR_W-1:0]      pattern_high_reg;
    logic [CARE_W-1:0]      care_mask_reg;
    logic [PAT_LEN_W-1:0]   pattern_length_reg;
    logic [ADDR_W-1:0]      region_start_reg;
    logic [ADDR_W-1:0]      module_base_reg;
    logic [HIT_LIMIT_W-1:0] hit_limit_reg;
    // region_start - module_base, kept current so a match needs one add
    logic [ADDR_W-1:0]      rel_base_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[APB_ADDR_W-1 -: 3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '1;
            pattern_length_reg <= PAT_LEN_W'(1);
            region_start_reg   <= '0;
            module_base_reg    <= '0;
            hit_limit_reg      <= '0;
            rel_base_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg   <= pwdata;
                REG_CARE_MASK:    care_mask_reg      <= pwdata[CARE_W-1:0];
                REG_PATTERN_LEN:  pattern_length_reg <= pwdata[PAT_LEN_W-1:0];
                REG_REGION_START:
                begin
                    region_start_reg <= pwdata;
                    rel_base_reg     <= pwdata - module_base_reg;
                end
                REG_MODULE_BASE:
                begin
                    module_base_reg <= pwdata;
                    rel_base_reg    <= region_start_reg - pwdata;
                end
                REG_HIT_LIMIT:    hit_limit_reg      <= pwdata[HIT_LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_CARE_MASK:    prdata = APB_DATA_W'(care_mask_reg);
            REG_PATTERN_LEN:  prdata = APB_DATA_W'(pattern_length_reg);
            REG_REGION_START: prdata = region_start_reg;
            REG_MODULE_BASE:  prdata = module_base_reg;
            REG_HIT_LIMIT:    prdata = APB_DATA_W'(hit_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     consume;          // input register item is processed this cycle

    assign byte_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_item_reg <= byte_item;
    end

    // ---------------- scan state ----------------
    logic [PATTERN_MAX-1:0][7:0] window_reg, window_next, win_shift;
    logic [SEEN_W-1:0]           seen_reg, seen_next, seen_inc;
    logic [CNT_W-1:0]            hits_reg, hits_next, hits_inc;
    logic                        ovf_reg, ovf_next, ovf_upd;

    // effective pattern length: 0 reads as 1, clipped to the window depth
    logic [LX_W-1:0] len_eff;
    always_comb
    begin
        if (pattern_length_reg == '0)
            len_eff = LX_W'(1);
        else if (LX_W'(pattern_length_reg) > LX_W'(PATTERN_MAX))
            len_eff = LX_W'(PATTERN_MAX);
        else
            len_eff = LX_W'(pattern_length_reg);
    end

    // effective hit limit: 0 or beyond the maximum reads as the maximum
    logic [CMP_W-1:0] lim_eff;
    always_comb
    begin
        if (hit_limit_reg == '0 || CMP_W'(hit_limit_reg) > CMP_W'(MAX_HITS))
            lim_eff = CMP_W'(MAX_HITS);
        else
            lim_eff = CMP_W'(hit_limit_reg);
    end

    // window after this byte shifts in (newest at the top)
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX - 1; i++)
            win_shift[i] = window_reg[i+1];
        win_shift[PATTERN_MAX-1] = in_item_reg.data_byte;
    end

    logic              window_match;
    logic              scanned;     // byte lies inside the 64 MiB limit
    logic              hit;
    logic [SEEN_W-1:0] off_full;

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .window       (win_shift),
        .pattern      ({pattern_high_reg, pattern_low_reg}),
        .care_mask    (care_mask_reg),
        .pattern_len  (len_eff),
        .window_match (window_match)
    );

    assign scanned  = !seen_reg[SEEN_W-1];
    assign seen_inc = seen_reg + SEEN_W'(1);
    assign off_full = seen_inc - SEEN_W'(len_eff);
    assign hit      = scanned && (seen_inc >= SEEN_W'(len_eff))
                   && (CMP_W'(hits_reg) < lim_eff) && window_match;
    assign hits_inc = hits_reg + CNT_W'(hit);
    assign ovf_upd  = ovf_reg || !scanned;

    // state update; a marked last byte returns everything to reset values
    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        hits_next   = hits_reg;
        ovf_next    = ovf_reg;
        if (consume)
        begin
            if (scanned)
            begin
                window_next = win_shift;
                seen_next   = seen_inc;
                hits_next   = hits_inc;
            end
            else
                ovf_next = 1'b1;
            if (in_item_reg.last_byte)
            begin
                window_next = '0;
                seen_next   = '0;
                hits_next   = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            hits_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            hits_reg   <= hits_next;
            ovf_reg    <= ovf_next;
        end
    end

    // ---------------- result items ----------------
    out_item_t match_item, sum_item;
    logic [OFFSET_W-1:0] match_off;

    assign match_off = off_full[OFFSET_W-1:0];

    always_comb
    begin
        match_item.result_kind    = KIND_MATCH;
        match_item.match_address  = region_start_reg + ADDR_W'(match_off);
        match_item.match_relative = rel_base_reg + ADDR_W'(match_off);
        match_item.match_offset   = match_off;
        match_item.hit_total      = HIT_TOTAL_W'(hits_inc);
        match_item.scan_status    = ovf_reg;
        match_item.final_result   = 1'b0;

        sum_item.result_kind      = KIND_SUMMARY;
        sum_item.match_address    = '0;
        sum_item.match_relative   = '0;
        sum_item.match_offset     = '0;
        sum_item.hit_total        = HIT_TOTAL_W'(hits_inc);
        sum_item.scan_status      = ovf_upd;
        sum_item.final_result     = 1'b1;
    end

    // ---------------- output register and summary holding register ----------
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      sum_valid_reg, sum_valid_next;
    out_item_t sum_item_reg, sum_item_next;
    logic      out_free;

    assign out_free = !out_valid_reg || result_ready;
    // a held summary goes out before the next byte is looked at
    assign consume  = out_free && !sum_valid_reg && in_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_item_next  = out_item_reg;
        sum_valid_next = sum_valid_reg;
        sum_item_next  = sum_item_reg;
        if (out_free)
        begin
            if (sum_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_item_next  = sum_item_reg;
                sum_valid_next = 1'b0;
            end
            else if (in_valid_reg)
            begin
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = match_item;
                    if (in_item_reg.last_byte)
                    begin
                        sum_valid_next = 1'b1;
                        sum_item_next  = sum_item;
                    end
                end
                else if (in_item_reg.last_byte)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = sum_item;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sum_valid_reg <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        sum_item_reg <= sum_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

// ----- rtl/wbps_checker.sv -----
// wbps_checker: port-level assertions for wildcard_byte_pattern_scan, and its bind.
// Depends on wbps_pkg; attaches to the top level.
module wbps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            byte_ready,
    input logic                            result_valid,
    input logic                            result_ready,
    input wbps_pkg::out_item_t             result_item
);
    import wbps_pkg::*;

    // a stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result transfer dropped or changed while stalled");

    // input only stalls behind a result that is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> result_valid)
        else $error("byte channel stalled with nothing in the output register");

    // summary carries no match location
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.result_kind == KIND_SUMMARY |->
            result_item.final_result && result_item.match_offset == '0
            && result_item.match_address == '0 && result_item.match_relative == '0)
        else $error("summary with match fields set or not final");

    // a match report is never the final result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.result_kind == KIND_MATCH |-> !result_item.final_result)
        else $error("match report marked final");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);

// ----- tb/scan_result_checker.sv -----
// scan_result_checker: predicts the scanner's match reports and end-of-scan summaries
// from the observed register writes and byte transfers, and compares result transfers.
// Depends on wbps_pkg for payload types, field widths and register codes.
`timescale 1ns / 100ps

module scan_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic                              pready,
    input  logic                              byte_valid,
    input  logic                              byte_ready,
    input  wbps_pkg::in_item_t                byte_item,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  wbps_pkg::out_item_t               result_item,
    output int unsigned                       awaited,
    output int unsigned                       mismatches
);
    import wbps_pkg::*;

    localparam int          WINDOW_DEPTH = 16;
    localparam int          HIT_CEILING  = 256;
    localparam int unsigned REGION_BYTES = 64 * 1024 * 1024;

    // register copies
    logic [63:0]            pattern_lo;
    logic [63:0]            pattern_hi;
    logic [CARE_W-1:0]      care;
    logic [PAT_LEN_W-1:0]   length_field;
    logic [63:0]            region_origin;
    logic [63:0]            module_origin;
    logic [HIT_LIMIT_W-1:0] limit_field;

    // scan state
    logic [7:0]             window [WINDOW_DEPTH];    // newest byte at the top index
    logic [SEEN_W-1:0]      seen;
    logic [HIT_TOTAL_W-1:0] hits;
    logic                   truncated;

    out_item_t              awaited_reports [$];

    task automatic report(input string what);
        $display("%0t ns: result mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic restart_scan();
        foreach (window[k])
            window[k] = 8'h00;
        seen      = '0;
        hits      = '0;
        truncated = 1'b0;
    endtask

    // One accepted byte: shift the window, test for a match, close the scan on the last byte.
    task automatic fold_byte(input in_item_t item);
        int unsigned  span;
        int unsigned  ceiling;
        logic [127:0] pattern;
        logic         hit;
        out_item_t    rpt;
        span    = (length_field == 0) ? 1 :
                  (length_field > WINDOW_DEPTH) ? WINDOW_DEPTH : length_field;
        ceiling = (limit_field == 0 || limit_field > HIT_CEILING) ? HIT_CEILING : limit_field;
        pattern = {pattern_hi, pattern_lo};
        if (seen >= REGION_BYTES)
        begin
            truncated = 1'b1;
        end
        else
        begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++)
                window[k] = window[k + 1];
            window[WINDOW_DEPTH - 1] = item.data_byte;
            seen = seen + 1'b1;
            if (seen >= span && hits < ceiling)
            begin
                hit = 1'b1;
                for (int k = 0; k < span; k++)
                    if (care[k] && window[WINDOW_DEPTH - span + k] != pattern[8 * k +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    hits               = hits + 1'b1;
                    rpt                = '0;
                    rpt.result_kind    = KIND_MATCH;
                    rpt.match_offset   = OFFSET_W'(seen - span);
                    rpt.match_address  = region_origin + 64'(rpt.match_offset);
                    rpt.match_relative = rpt.match_address - module_origin;
                    rpt.hit_total      = hits;
                    rpt.scan_status    = truncated;
                    rpt.final_result   = 1'b0;
                    awaited_reports.insert(awaited_reports.size(), rpt);
                end
            end
        end
        if (item.last_byte)
        begin
            rpt              = '0;
            rpt.result_kind  = KIND_SUMMARY;
            rpt.hit_total    = hits;
            rpt.scan_status  = truncated;
            rpt.final_result = 1'b1;
            awaited_reports.insert(awaited_reports.size(), rpt);
            restart_scan();
        end
    endtask

    task automatic compare(input out_item_t got);
        out_item_t want;
        if (awaited_reports.size() == 0)
        begin
            report($sformatf("unexpected result 0x%0h", got));
            return;
        end
        want = awaited_reports.pop_front();
        check_field("result_kind",    64'(got.result_kind),    64'(want.result_kind));
        check_field("match_address",  got.match_address,       want.match_address);
        check_field("match_relative", got.match_relative,      want.match_relative);
        check_field("match_offset",   64'(got.match_offset),   64'(want.match_offset));
        check_field("hit_total",      64'(got.hit_total),      64'(want.hit_total));
        check_field("scan_status",    64'(got.scan_status),    64'(want.scan_status));
        check_field("final_result",   64'(got.final_result),   64'(want.final_result));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_lo    = '0;
            pattern_hi    = '0;
            care          = '1;
            length_field  = PAT_LEN_W'(1);
            region_origin = '0;
            module_origin = '0;
            limit_field   = '0;
            restart_scan();
            awaited_reports.delete();
            mismatches    = 0;
            awaited      <= 0;
        end
        else
        begin
            // results first: a byte taken at this edge cannot have produced one yet
            if (result_valid && result_ready)
                compare(result_item);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:3])
                    REG_PATTERN_LOW:  pattern_lo    = pwdata;
                    REG_PATTERN_HIGH: pattern_hi    = pwdata;
                    REG_CARE_MASK:    care          = pwdata[CARE_W-1:0];
                    REG_PATTERN_LEN:  length_field  = pwdata[PAT_LEN_W-1:0];
                    REG_REGION_START: region_origin = pwdata;
                    REG_MODULE_BASE:  module_origin = pwdata;
                    REG_HIT_LIMIT:    limit_field   = pwdata[HIT_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (byte_valid && byte_ready)
                fold_byte(byte_item);
            awaited <= awaited_reports.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// tb: stimulus and verdict for wildcard_byte_pattern_scan.
// Programs the APB registers, streams byte regions and stalls the result side;
// prediction and comparison sit in scan_result_checker. Uses wbps_pkg.
`timescale 1ns / 100ps

module tb;
    import wbps_pkg::*;

    localparam int RANDOM_BYTES  = 600;
    // byte register, compare stage, output register, plus the summary slot behind a match
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT_NS  = 6_000_000;

    typedef enum logic [1:0] {
        READY_STEADY,   // never stalls
        READY_COIN,     // stalls half the time
        READY_SPARSE,   // ready a quarter of the time, at random
        READY_BURSTY    // mostly ready, with long stalls now and then
    } ready_style_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  byte_valid   = 1'b0;
    logic                  byte_ready;
    in_item_t              byte_item    = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result_item;

    int unsigned           awaited;
    int unsigned           mismatches;

    // sender and receiver pacing
    int                    burst_left   = 0;
    int                    bytes_sent   = 0;
    ready_style_t          ready_style  = READY_STEADY;
    int                    style_left   = 0;
    int                    stall_left   = 0;

    // current setup, used only to plant occurrences of the pattern
    logic [127:0]          pat_bits;    // pattern byte k at [8k +: 8]
    logic [15:0]           care_bits;
    int                    eff_len;

    wildcard_byte_pattern_scan i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    scan_result_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .awaited      (awaited),
        .mismatches   (mismatches)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: the stall style is picked anew whenever its random run length runs out, so stalls land on
    // match reports, summaries and the back-to-back match/summary pair alike.
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 150);
        end
        style_left--;
        case (ready_style)
            READY_STEADY: result_ready <= 1'b1;
            READY_COIN:   result_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    result_ready <= 1'b0;
                end
                else
                begin
                    result_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(3, 12);
                end
            end
        endcase
    end

    // Narrow registers sometimes get random upper bits; only the low bits may count.
    function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return v;
        return (junk << w) | v;
    endfunction

    function automatic logic [63:0] any_addr();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // APB write: setup cycle, then access; psel stays up across back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Wait until every expected result has come back, then let any byte that
    // produces no result drain out of the pipeline.
    task automatic settle();
        byte_valid <= 1'b0;
        burst_left  = 0;
        repeat (2) @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] care, input logic [4:0] len_field,
                               input logic [63:0] start, input logic [63:0] base,
                               input logic [8:0] cap);
        settle();
        write_reg(REG_PATTERN_LOW,  lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK,    with_junk(64'(care), CARE_W));
        write_reg(REG_PATTERN_LEN,  with_junk(64'(len_field), PAT_LEN_W));
        write_reg(REG_REGION_START, start);
        write_reg(REG_MODULE_BASE,  base);
        write_reg(REG_HIT_LIMIT,    with_junk(64'(cap), HIT_LIMIT_W));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pat_bits  = {hi, lo};
        care_bits = care;
        eff_len   = (len_field == 0) ? 1 : (len_field > 16) ? 16 : len_field;
    endtask

    // One byte transfer. Bursts of random length with random gaps; valid is only
    // dropped when a gap starts, never between two bytes of a burst.
    task automatic push_byte(input logic [7:0] data, input logic last);
        in_item_t item;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item.data_byte = data;
        item.last_byte = last;
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
            @(posedge clk);
        while (!byte_ready);
        bytes_sent++;
    endtask

    // Region content: random bytes, bytes drawn from the pattern (near misses) and
    // full planted occurrences with random wildcard bytes.
    task automatic send_region(input int span, input bit close);
        logic [7:0] region_q [$];
        while (region_q.size() < span)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                for (int k = 0; k < eff_len; k++)
                    region_q.insert(region_q.size(),
                                    care_bits[k] ? pat_bits[8 * k +: 8] : 8'($urandom));
            end
            else if ($urandom_range(0, 1) == 0)
                region_q.insert(region_q.size(),
                                pat_bits[8 * $urandom_range(0, eff_len - 1) +: 8]);
            else
                region_q.insert(region_q.size(), 8'($urandom));
        end
        foreach (region_q[i])
            push_byte(region_q[i], close && (i == region_q.size() - 1));
    endtask

    // New setup, then a few regions. With leave_open the last region is not
    // terminated, so the next setup lands in the middle of a scan.
    task automatic random_phase(input bit leave_open);
        logic [4:0]  len_field;
        logic [15:0] care;
        logic [8:0]  cap;
        int          pick;
        int          regions;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       len_field = 5'd0;
            1:       len_field = 5'($urandom_range(17, 31));
            2:       len_field = 5'd16;
            default: len_field = 5'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       care = 16'($urandom);
            1:       care = '0;
            2, 3, 4: care = '1;
            default: care = ~(16'h0001 << $urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 7))
            0:       cap = '0;
            1:       cap = 9'd1;
            2:       cap = 9'd256;
            3:       cap = 9'($urandom_range(257, 511));
            default: cap = 9'($urandom_range(2, 6));
        endcase
        load_config({$urandom, $urandom}, {$urandom, $urandom}, care, len_field,
                    any_addr(), any_addr(), cap);
        regions = $urandom_range(1, 4);
        for (int r = 0; r < regions; r++)
            send_region($urandom_range(1, 3 * eff_len + 10), !(leave_open && r == regions - 1));
    endtask

    initial
    begin
        int  stop_at;
        bit  saturated;
        saturated = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: one-byte pattern 0x00, all bytes cared, built-in hit maximum.
        pat_bits  = '0;
        care_bits = '1;
        eff_len   = 1;
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        // DE AD ?? EF with a hit limit of one: the second occurrence is dropped.
        // Region starts at the top of the address space, so the match address
        // wraps to zero and the relative address wraps below the module base.
        load_config(64'h0000_0000_EF00_ADDE, '0, 16'h000B, 5'd4,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0010, 9'd1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hEF, 1'b0);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'h99, 1'b0);
        push_byte(8'hEF, 1'b1);

        // Length field above the maximum (clamps to 16), hit limit above the maximum.
        // A one-byte region is shorter than the pattern: summary only. Then an exact
        // 16-byte match whose last byte also ends the region: report plus summary.
        load_config(64'h8040_2010_0804_0201, 64'hFF7F_3F1F_0F07_0301, 16'hFFFF, 5'd31,
                    64'h0000_0000_4000_0000, 64'h0000_0000_3FFF_F000, 9'd300);
        push_byte(8'h01, 1'b1);
        for (int k = 0; k < 16; k++)
            push_byte(pat_bits[8 * k +: 8], k == 15);

        // Random part. One long all-wildcard region runs into the hit ceiling.
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            if (!saturated && bytes_sent > stop_at - RANDOM_BYTES + 150)
            begin
                load_config({$urandom, $urandom}, {$urandom, $urandom}, '0,
                            5'($urandom_range(1, 2)), 64'hFFFF_FFFF_FFFF_FFFF - 50,
                            any_addr(), ($urandom_range(0, 1) == 0) ? 9'd0 : 9'd300);
                send_region(280, 1'b1);
                saturated = 1'b1;
            end
            random_phase($urandom_range(0, 3) == 0);
        end
        push_byte(8'($urandom), 1'b1);
        settle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- wildcard_byte_pattern_scan.f -----
rtl/wbps_pkg.sv
rtl/wbps_match.sv
rtl/wildcard_byte_pattern_scan.sv
rtl/wbps_checker.sv
tb/scan_result_checker.sv
tb/tb.sv
